// File: rtl/srv_pkg.sv
// ----------------------------------------------------------------------------
// srv_pkg: shared constants and types for the refraction pipeline
// work format is q.14 on 16-bit scalars, plus bundles carried between stages
// ----------------------------------------------------------------------------
package srv_pkg;

	localparam int VECTOR_WIDTH_DEF = 16;
	localparam int WORK_W           = 16;
	localparam int INDEX_W          = 16;
	// one quotient bit per stage for (2^26 + g/2) / g
	localparam int DIV_STAGES       = 27;
	// one root bit per stage over a 64-bit radicand
	localparam int ROOT_STAGES      = 32;

	typedef logic signed [WORK_W-1:0] work_t;
	typedef logic signed [29:0]       scl_t;
	typedef logic signed [23:0]       mir_t;
	typedef logic signed [16:0]       side_t;

	typedef struct packed {
		work_t [2:0]        dv;
		work_t [2:0]        nv;
		logic signed [19:0] proj;
		logic [18:0]        cabs;
		logic               back_hit;
		logic [INDEX_W-1:0] g;
	} pre_t;

	typedef struct packed {
		logic         tir;
		logic [31:0]  gc;
		scl_t [2:0]   gd;
		mir_t [2:0]   mir;
		side_t [2:0]  side;
	} post_t;

endpackage

// File: rtl/srv_div.sv
// ----------------------------------------------------------------------------
// srv_div: pipelined restoring divider
// one quotient bit per register stage, advances on en
// ----------------------------------------------------------------------------
module srv_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic [srv_pkg::INDEX_W-1:0]       divisor,
	input  logic [srv_pkg::DIV_STAGES-1:0]    dividend,
	output logic [srv_pkg::DIV_STAGES-1:0]    quot
);

	localparam int N  = srv_pkg::DIV_STAGES;
	localparam int DW = srv_pkg::INDEX_W;

	logic [DW-1:0] rem_s [N];
	logic [N-1:0]  num_s [N];
	logic [N-1:0]  q_s   [N];
	logic [DW-1:0] d_s   [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [DW-1:0] d_in;
		logic [N-1:0]  num_in;
		logic [N-1:0]  q_in;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = dividend;
			assign q_in   = '0;
			assign d_in   = divisor;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign num_in = num_s[k-1];
			assign q_in   = q_s[k-1];
			assign d_in   = d_s[k-1];
		end

		assign trial = {rem_in, num_in[N-1]};
		assign ge    = trial >= {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
				num_s[k] <= {num_in[N-2:0], 1'b0};
				q_s[k]   <= {q_in[N-2:0], ge};
				d_s[k]   <= d_in;
			end
		end
	end

	assign quot = q_s[N-1];

endmodule

// File: rtl/srv_sqrt.sv
// ----------------------------------------------------------------------------
// srv_sqrt: pipelined integer square root
// floor root of a 64-bit radicand, one root bit per register stage
// ----------------------------------------------------------------------------
module srv_sqrt (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [2*srv_pkg::ROOT_STAGES-1:0]    rad,
	output logic [srv_pkg::ROOT_STAGES-1:0]      root
);

	localparam int RW    = srv_pkg::ROOT_STAGES;
	localparam int XW    = 2 * RW;
	localparam int REM_W = RW + 2;

	logic [REM_W-1:0] rem_s  [RW];
	logic [RW-1:0]    root_s [RW];
	logic [XW-1:0]    x_s    [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [REM_W-1:0] rem_in;
		logic [RW-1:0]    root_in;
		logic [XW-1:0]    x_in;
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = rad;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign x_in    = x_s[k-1];
		end

		assign cur   = {rem_in, x_in[XW-1:XW-2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
				root_s[k] <= {root_in[RW-2:0], ge};
				x_s[k]    <= {x_in[XW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[RW-1];

endmodule

// File: rtl/snell_refraction_vector_top.sv
// ----------------------------------------------------------------------------
// snell_refraction_vector_top: refraction by snell's law with mirror fallback
// one beat accepted per cycle unless the output is stalled; depth set by
// the 27-stage index divider and the 32-stage square root, each producing
// one bit per stage
// a full output register holds every stage while m_tready is low
// arst_n clears only the valid bits, data registers are not reset
// ----------------------------------------------------------------------------
module snell_refraction_vector_top #(
	parameter int VECTOR_WIDTH = srv_pkg::VECTOR_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// inc_x, inc_y, inc_z, nrm_x, nrm_y, nrm_z, index_ratio, zero fill
	input  logic [((6*VECTOR_WIDTH+srv_pkg::INDEX_W+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// dir_x, dir_y, dir_z, zero fill
	output logic [((3*VECTOR_WIDTH+7)/8)*8-1:0] m_tdata,
	// internal_reflection
	output logic m_tuser
);

	localparam int VW    = VECTOR_WIDTH;
	localparam int OUT_W = ((3*VW+7)/8)*8;
	localparam int LAT   = srv_pkg::DIV_STAGES + srv_pkg::ROOT_STAGES + 11;
	localparam int DN    = srv_pkg::DIV_STAGES;
	localparam int RN    = srv_pkg::ROOT_STAGES;
	localparam int RES_W = 38;
	localparam int SW    = RES_W + ((VW > 16) ? (VW - 16) : 0);

	logic           en;
	logic [LAT:1]   vld_s;

	assign en       = ~vld_s[LAT] | m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], s_tvalid};
		end
	end

	// input load into q.14
	srv_pkg::work_t dv_in [3];
	srv_pkg::work_t nv_in [3];

	for (genvar k = 0; k < 3; k++) begin : g_load
		logic [VW-1:0] inc_raw;
		logic [VW-1:0] nrm_raw;
		assign inc_raw = s_tdata[k*VW +: VW];
		assign nrm_raw = s_tdata[(3+k)*VW +: VW];
		if (VW == 16) begin : g_eq
			assign dv_in[k] = inc_raw;
			assign nv_in[k] = nrm_raw;
		end else if (VW < 16) begin : g_lt
			assign dv_in[k] = {inc_raw, {(16-VW){1'b0}}};
			assign nv_in[k] = {nrm_raw, {(16-VW){1'b0}}};
		end else begin : g_gt
			assign dv_in[k] = inc_raw[VW-1:VW-16];
			assign nv_in[k] = nrm_raw[VW-1:VW-16];
		end
	end

	// stage 1
	srv_pkg::work_t           dv_s1 [3];
	srv_pkg::work_t           nv_s1 [3];
	logic signed [31:0]       prod_s1 [3];
	logic [srv_pkg::INDEX_W-1:0] g_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dv_s1[k]   <= dv_in[k];
				nv_s1[k]   <= nv_in[k];
				prod_s1[k] <= dv_in[k] * nv_in[k];
			end
			g_s1 <= s_tdata[6*VW +: srv_pkg::INDEX_W];
		end
	end

	// inverse index, runs beside the delay line
	logic [srv_pkg::INDEX_W-1:0] g_div;
	logic [DN-1:0]               num_div;
	logic [DN-1:0]               quot;

	assign g_div   = (g_s1 == '0) ? srv_pkg::INDEX_W'(1) : g_s1;
	assign num_div = (DN'(1) << (DN - 1)) + DN'(g_div >> 1);

	srv_div u_div (
		.clk      (clk),
		.en       (en),
		.divisor  (g_div),
		.dividend (num_div),
		.quot     (quot)
	);

	// stage 2: projection and side of the hit
	logic signed [33:0] dot_c;
	logic signed [19:0] proj_c;
	logic signed [19:0] nproj_c;
	srv_pkg::pre_t      pre_s2;
	srv_pkg::pre_t      pre_dly_s [DN-1];

	assign dot_c   = 34'(prod_s1[0]) + 34'(prod_s1[1]) + 34'(prod_s1[2]) + 34'sd8192;
	assign proj_c  = dot_c[33:14];
	assign nproj_c = -proj_c;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pre_s2.dv[k] <= dv_s1[k];
				pre_s2.nv[k] <= nv_s1[k];
			end
			pre_s2.proj     <= proj_c;
			pre_s2.back_hit <= proj_c > 20'sd0;
			pre_s2.cabs     <= (proj_c > 20'sd0) ? proj_c[18:0] : nproj_c[18:0];
			pre_s2.g        <= g_s1;
			pre_dly_s[0]    <= pre_s2;
			for (int k = 1; k < DN - 1; k++) begin
				pre_dly_s[k] <= pre_dly_s[k-1];
			end
		end
	end

	// stage 29: gain and oriented normal
	srv_pkg::pre_t      pre28;
	logic [26:0]        gain_s29;
	srv_pkg::side_t     side_s29 [3];
	logic signed [20:0] twice_s29;
	srv_pkg::work_t     dv_s29 [3];
	srv_pkg::work_t     nv_s29 [3];
	logic [18:0]        cabs_s29;

	assign pre28 = pre_dly_s[DN-2];

	always_ff @(posedge clk) begin
		if (en) begin
			gain_s29  <= pre28.back_hit ? 27'(quot) : {9'd0, pre28.g, 2'b00};
			twice_s29 <= -$signed({pre28.proj, 1'b0});
			cabs_s29  <= pre28.cabs;
			for (int k = 0; k < 3; k++) begin
				dv_s29[k]   <= pre28.dv[k];
				nv_s29[k]   <= pre28.nv[k];
				side_s29[k] <= pre28.back_hit ? -17'($signed(pre28.nv[k]))
				                              : 17'($signed(pre28.nv[k]));
			end
		end
	end

	// stage 30: products
	logic [53:0]        gg_raw_s30;
	logic [37:0]        cc_raw_s30;
	logic [45:0]        gc_raw_s30;
	logic signed [43:0] gd_raw_s30 [3];
	logic signed [36:0] tn_raw_s30 [3];
	srv_pkg::work_t     dv_s30 [3];
	srv_pkg::side_t     side_s30 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			gg_raw_s30 <= gain_s29 * gain_s29;
			cc_raw_s30 <= cabs_s29 * cabs_s29;
			gc_raw_s30 <= gain_s29 * cabs_s29;
			for (int k = 0; k < 3; k++) begin
				gd_raw_s30[k] <= $signed({1'b0, gain_s29}) * dv_s29[k];
				tn_raw_s30[k] <= twice_s29 * nv_s29[k];
				dv_s30[k]     <= dv_s29[k];
				side_s30[k]   <= side_s29[k];
			end
		end
	end

	// stage 31: rounding back to q.14
	logic [53:0]        gg_rnd;
	logic [37:0]        cc_rnd;
	logic [45:0]        gc_rnd;
	logic signed [43:0] gd_rnd [3];
	logic signed [36:0] tn_rnd [3];
	logic [39:0]        gg_s31;
	logic signed [24:0] t_s31;
	srv_pkg::post_t     post_s31;

	assign gg_rnd = gg_raw_s30 + 54'd8192;
	assign cc_rnd = cc_raw_s30 + 38'd8192;
	assign gc_rnd = gc_raw_s30 + 46'd8192;
	for (genvar k = 0; k < 3; k++) begin : g_rnd31
		assign gd_rnd[k] = gd_raw_s30[k] + 44'sd8192;
		assign tn_rnd[k] = tn_raw_s30[k] + 37'sd8192;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gg_s31       <= gg_rnd[53:14];
			t_s31        <= 25'sd16384 - $signed({1'b0, cc_rnd[37:14]});
			post_s31.tir <= 1'b0;
			post_s31.gc  <= gc_rnd[45:14];
			for (int k = 0; k < 3; k++) begin
				post_s31.gd[k]   <= gd_rnd[k][43:14];
				post_s31.mir[k]  <= 24'($signed(dv_s30[k])) + 24'($signed(tn_rnd[k][36:14]));
				post_s31.side[k] <= side_s30[k];
			end
		end
	end

	// stage 32: split product gg * t
	logic signed [45:0] hi_s32;
	logic signed [45:0] lo_s32;
	srv_pkg::post_t     post_s32;

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s32   <= $signed({1'b0, gg_s31[39:20]}) * t_s31;
			lo_s32   <= $signed({1'b0, gg_s31[19:0]}) * t_s31;
			post_s32 <= post_s31;
		end
	end

	// stage 33: recombine and round
	logic signed [63:0] pp_c;
	logic signed [49:0] q_s33;
	srv_pkg::post_t     post_s33;

	assign pp_c = (64'(hi_s32) <<< 20) + 64'(lo_s32) + 64'sd8192;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s33    <= pp_c[63:14];
			post_s33 <= post_s32;
		end
	end

	// stage 34: radicand and reflection decision
	logic signed [51:0] under_c;
	logic [2*RN-1:0]    rad_s34;
	srv_pkg::post_t     post_c;
	srv_pkg::post_t     post_s34;

	assign under_c = 52'sd16384 - 52'(q_s33);

	always_comb begin
		post_c     = post_s33;
		post_c.tir = under_c[51];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s34  <= {under_c[49:0], 14'd0};
			post_s34 <= post_c;
		end
	end

	logic [RN-1:0]  root;
	srv_pkg::post_t post_dly_s [RN];

	srv_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s34),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			post_dly_s[0] <= post_s34;
			for (int k = 1; k < RN; k++) begin
				post_dly_s[k] <= post_dly_s[k-1];
			end
		end
	end

	// stage 67: blend factor
	logic signed [33:0] blend_s67;
	srv_pkg::post_t     post_s67;

	always_ff @(posedge clk) begin
		if (en) begin
			blend_s67 <= $signed({2'b00, post_dly_s[RN-1].gc}) - $signed({2'b00, root});
			post_s67  <= post_dly_s[RN-1];
		end
	end

	// stage 68: blend times oriented normal
	logic signed [50:0] bs_s68 [3];
	srv_pkg::post_t     post_s68;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				bs_s68[k] <= blend_s67 * $signed(post_s67.side[k]);
			end
			post_s68 <= post_s67;
		end
	end

	// stage 69: refracted or mirrored direction
	logic signed [50:0]      bs_rnd [3];
	logic signed [RES_W-1:0] res_s69 [3];
	logic                    tir_s69;

	for (genvar k = 0; k < 3; k++) begin : g_rnd69
		assign bs_rnd[k] = bs_s68[k] + 51'sd8192;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				res_s69[k] <= post_s68.tir ? RES_W'($signed(post_s68.mir[k]))
				            : RES_W'($signed(post_s68.gd[k]))
				              + RES_W'($signed(bs_rnd[k][50:14]));
			end
			tir_s69 <= post_s68.tir;
		end
	end

	// stage 70: output format and saturation
	logic [VW-1:0] dir_c [3];
	logic [VW-1:0] dir_s70 [3];
	logic          tir_s70;

	for (genvar k = 0; k < 3; k++) begin : g_store
		logic signed [SW-1:0] shv;
		logic signed [SW-1:0] top_v;
		logic signed [SW-1:0] bot_v;
		if (VW >= 16) begin : g_up
			assign shv = SW'(res_s69[k]) <<< (VW - 16);
		end else begin : g_dn
			assign shv = SW'(res_s69[k] >>> (16 - VW));
		end
		assign top_v = SW'((longint'(1) <<< (VW - 1)) - longint'(1));
		assign bot_v = ~top_v;
		assign dir_c[k] = (shv > top_v) ? top_v[VW-1:0]
		                : (shv < bot_v) ? bot_v[VW-1:0] : shv[VW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dir_s70[k] <= dir_c[k];
			end
			tir_s70 <= tir_s69;
		end
	end

	assign m_tdata = OUT_W'({dir_s70[2], dir_s70[1], dir_s70[0]});
	assign m_tuser = tir_s70;

endmodule

// File: rtl/srv_checker.sv
// ----------------------------------------------------------------------------
// srv_checker: port-level checks for the refraction pipeline
// bound to the top level, watches handshake and stall behavior
// ----------------------------------------------------------------------------
module srv_checker #(
	parameter int VECTOR_WIDTH = srv_pkg::VECTOR_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((3*VECTOR_WIDTH+7)/8)*8-1:0] m_tdata,
	input logic m_tuser
);

	// a stalled result beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// the whole pipe stalls only on a full, blocked output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// a new result only appears when the pipe advanced
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tready))
		else $error("result appeared during a stall");

	// no result while reset is held
	a_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// an input held off while the output is blocked stays offered to nothing new
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> m_tvalid)
		else $error("input stalled without a pending result");

endmodule

bind snell_refraction_vector_top srv_checker #(
	.VECTOR_WIDTH (VECTOR_WIDTH)
) u_srv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
